FILE: rtl/dcrc_pkg.sv
// ============================================================================
// dcrc_pkg: shared types and constants of the DMA channel register controller
// Register map codes, decoded access and start descriptor structs.
// ============================================================================
package dcrc_pkg;

   // Number of implemented channels (1 to 7).
   localparam int CHANNELS = 7;
   localparam logic [2:0] CHAN_LIMIT = 3'(CHANNELS);

   // Bus command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Channel number that selects the common register block.
   localparam logic [2:0] COMMON_CHAN = 3'd7;

   // Per-channel register codes.
   localparam logic [1:0] REG_BASE   = 2'd0;
   localparam logic [1:0] REG_SIZE   = 2'd1;
   localparam logic [1:0] REG_CTRL   = 2'd2;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   // Common block register codes.
   localparam logic [1:0] REG_PRIMARY = 2'd0;
   localparam logic [1:0] REG_IRQ     = 2'd1;

   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   // Decoded bus access as seen by the register blocks.
   typedef struct packed {
      logic        strobe;   // access commits this cycle
      logic        write;
      logic [2:0]  chan;
      logic [1:0]  regsel;
      logic [31:0] value;    // write data already moved to its byte lane
   } access_type;

   // Transfer descriptor issued by a channel write.
   typedef struct packed {
      logic        valid;
      logic [2:0]  chan;
      logic        linked_list;
      logic        to_ram;
      logic        decrement;
      logic [23:0] base;
      logic [31:0] words;
      logic        completes;
   } start_type;

endpackage

FILE: rtl/dcrc_req_if.sv
// ============================================================================
// dcrc_req_if: request channel of the DMA channel register controller
// One bus access per item: command, register offset and write data.
// ============================================================================
interface dcrc_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [7:0]  reg_offset;
   logic [31:0] write_data;

   modport source (output valid, command, reg_offset, write_data, input ready);
   modport sink   (input valid, command, reg_offset, write_data, output ready);
endinterface

FILE: rtl/dcrc_rsp_if.sv
// ============================================================================
// dcrc_rsp_if: response channel of the DMA channel register controller
// Read data, interrupt level and the transfer descriptor of one access.
// ============================================================================
interface dcrc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic        irq_level;
   logic        start_valid;
   logic [2:0]  start_channel;
   logic        start_linked_list;
   logic        start_to_ram;
   logic        start_decrement;
   logic [23:0] start_base;
   logic [31:0] start_words;
   logic        start_completes;

   modport source (output valid, read_data, irq_level, start_valid, start_channel,
                   start_linked_list, start_to_ram, start_decrement, start_base,
                   start_words, start_completes, input ready);
   modport sink   (input valid, read_data, irq_level, start_valid, start_channel,
                   start_linked_list, start_to_ram, start_decrement, start_base,
                   start_words, start_completes, output ready);
endinterface

FILE: rtl/dcrc_chan_regs.sv
// ============================================================================
// dcrc_chan_regs: per-channel base, size/count and control registers
// Applies channel writes, detects a channel going active, builds descriptors.
// ============================================================================
module dcrc_chan_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  dcrc_pkg::access_type           access,
   input  logic [dcrc_pkg::CHANNELS-1:0]  master_en,
   output dcrc_pkg::start_type            start,
   output logic [31:0]                    rd_value
);

   // control bits: 0 from-RAM, 1 decrement, 2 chop, 4:3 sync, 7:5 chop dma,
   // 10:8 chop cpu, 11 enable, 12 trigger, 14:13 unknown
   localparam int CTRL_ENABLE  = 11;
   localparam int CTRL_TRIGGER = 12;
   localparam logic [1:0] SYNC_MANUAL = 2'd0;
   localparam logic [1:0] SYNC_LIST   = 2'd2;
   localparam logic [1:0] SYNC_KEEP   = 2'd3;
   localparam logic [2:0] FORCED_CHAN = 3'd6;
   localparam logic [2:0] LIST_CHAN   = 3'd2;

   logic [23:0] base_ff  [dcrc_pkg::CHANNELS];
   logic [16:0] size_ff  [dcrc_pkg::CHANNELS];
   logic [15:0] count_ff [dcrc_pkg::CHANNELS];
   logic [14:0] ctrl_ff  [dcrc_pkg::CHANNELS];

   logic [2:0]  idx;
   logic        sel;
   logic        commit;
   logic [23:0] base_in;
   logic [16:0] size_in;
   logic [15:0] count_in;
   logic [14:0] ctrl_new;
   logic [14:0] ctrl_in;
   logic [1:0]  sync;
   logic        active;
   logic [31:0] product;

   function automatic logic [14:0] ctrl_pack(input logic [2:0] ch, input logic [14:0] old,
                                             input logic [31:0] v);
      logic [14:0] c;
      c = '0;
      if (ch == FORCED_CHAN) begin
         c[1]            = 1'b1;
         c[CTRL_ENABLE]  = v[24];
         c[CTRL_TRIGGER] = v[28];
         c[14]           = v[30];
      end else begin
         c[0]            = v[0];
         c[1]            = v[1];
         c[2]            = v[8];
         c[4:3]          = (v[10:9] == SYNC_KEEP) ? old[4:3] : v[10:9];
         c[7:5]          = v[18:16];
         c[10:8]         = v[22:20];
         c[CTRL_ENABLE]  = v[24];
         c[CTRL_TRIGGER] = v[28];
         c[14:13]        = v[30:29];
      end
      return c;
   endfunction

   function automatic logic [31:0] ctrl_view(input logic [14:0] c);
      logic [31:0] v;
      v        = '0;
      v[0]     = c[0];
      v[1]     = c[1];
      v[8]     = c[2];
      v[10:9]  = c[4:3];
      v[18:16] = c[7:5];
      v[22:20] = c[10:8];
      v[24]    = c[CTRL_ENABLE];
      v[28]    = c[CTRL_TRIGGER];
      v[30:29] = c[14:13];
      return v;
   endfunction

   assign idx    = access.chan;
   assign sel    = (idx < dcrc_pkg::CHAN_LIMIT) && (idx != dcrc_pkg::COMMON_CHAN) &&
                   (access.regsel != dcrc_pkg::REG_UNUSED);
   assign commit = access.strobe && access.write && sel;

   always_comb begin
      base_in  = base_ff[idx];
      size_in  = size_ff[idx];
      count_in = count_ff[idx];
      ctrl_new = ctrl_ff[idx];
      case (access.regsel)
         dcrc_pkg::REG_BASE: begin
            base_in = access.value[23:0];
         end
         dcrc_pkg::REG_SIZE: begin
            // size zero means a full 64K block
            size_in  = (access.value[15:0] == 16'd0) ? 17'h10000 : {1'b0, access.value[15:0]};
            count_in = access.value[31:16];
         end
         dcrc_pkg::REG_CTRL: begin
            ctrl_new = ctrl_pack(idx, ctrl_ff[idx], access.value);
         end
         default: begin
            ctrl_new = ctrl_ff[idx];
         end
      endcase
   end

   assign sync    = ctrl_new[4:3];
   assign active  = access.write && sel && master_en[idx] && ctrl_new[CTRL_ENABLE] &&
                    ((sync != SYNC_MANUAL) || ctrl_new[CTRL_TRIGGER]);
   // 16-bit count times at most 0x10000 always fits in 32 bits
   assign product = 32'(count_in) * 32'(size_in);
   assign ctrl_in = active ? (ctrl_new & ~(15'(1) << CTRL_ENABLE) & ~(15'(1) << CTRL_TRIGGER))
                           : ctrl_new;

   always_comb begin
      start = '0;
      if (active) begin
         start.valid       = 1'b1;
         start.chan        = idx;
         start.linked_list = (sync == SYNC_LIST);
         start.to_ram      = !ctrl_new[0];
         start.decrement   = ctrl_new[1];
         start.base        = base_in;
         if (sync == SYNC_LIST) begin
            start.words     = '0;
            start.completes = ctrl_new[0] && (idx == LIST_CHAN);
         end else begin
            start.words     = (sync == SYNC_MANUAL) ? 32'(size_in) : product;
            start.completes = !ctrl_new[0] || (idx inside {3'd0, 3'd2, 3'd4});
         end
      end
   end

   always_comb begin
      case (access.regsel)
         dcrc_pkg::REG_BASE: rd_value = {8'd0, base_ff[idx]};
         dcrc_pkg::REG_SIZE: rd_value = {count_ff[idx], 16'd0} | {15'd0, size_ff[idx]};
         dcrc_pkg::REG_CTRL: rd_value = ctrl_view(ctrl_ff[idx]);
         default:            rd_value = dcrc_pkg::ALL_ONES;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < dcrc_pkg::CHANNELS; i++) begin
            base_ff[i]  <= '0;
            size_ff[i]  <= '0;
            count_ff[i] <= '0;
            ctrl_ff[i]  <= '0;
         end
      end else if (commit) begin
         base_ff[idx]  <= base_in;
         size_ff[idx]  <= size_in;
         count_ff[idx] <= count_in;
         ctrl_ff[idx]  <= ctrl_in;
      end
   end

   // a started channel drops its enable bit
   assert property (@(posedge clock) disable iff (reset)
      access.strobe && start.valid |=> !ctrl_ff[$past(idx)][CTRL_ENABLE])
      else $error("channel stayed enabled after start");

endmodule

FILE: rtl/dcrc_common_regs.sv
// ============================================================================
// dcrc_common_regs: primary control word and interrupt register
// Holds master enables and interrupt master/enable/flag bits.
// ============================================================================
module dcrc_common_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  dcrc_pkg::access_type           access,
   input  dcrc_pkg::start_type            start,
   output logic [dcrc_pkg::CHANNELS-1:0]  master_en,
   output logic                           irq_next,
   output logic [31:0]                    rd_value
);

   localparam logic [31:0] PRIMARY_RESET = 32'h0765_4321;

   // interrupt mode bits are write-only and never observed, so not kept
   logic [31:0] primary_ff, primary_in;
   logic        master_ff, master_in;
   logic [6:0]  enable_ff, enable_in;
   logic [6:0]  flag_ff, flag_in;
   logic        sel;
   logic        line;

   assign sel  = access.strobe && access.write && (access.chan == dcrc_pkg::COMMON_CHAN);
   assign line = master_ff && |(flag_ff & enable_ff);

   always_comb begin
      for (int i = 0; i < dcrc_pkg::CHANNELS; i++) begin
         master_en[i] = primary_ff[3 + 4 * i];
      end
   end

   always_comb begin
      primary_in = primary_ff;
      master_in  = master_ff;
      enable_in  = enable_ff;
      flag_in    = flag_ff;
      if (sel && access.regsel == dcrc_pkg::REG_PRIMARY) begin
         primary_in = access.value;
      end
      if (sel && access.regsel == dcrc_pkg::REG_IRQ) begin
         master_in = access.value[23];
         enable_in = access.value[22:16];
         flag_in   = flag_ff & ~access.value[30:24];   // write one to clear
      end
      if (access.strobe && start.valid && start.completes) begin
         flag_in = flag_ff | (enable_ff & (7'd1 << start.chan));
      end
   end

   assign irq_next = master_in && |(flag_in & enable_in);

   always_comb begin
      case (access.regsel)
         dcrc_pkg::REG_PRIMARY: rd_value = primary_ff;
         dcrc_pkg::REG_IRQ:     rd_value = {line, flag_ff, master_ff, enable_ff, 16'd0};
         default:               rd_value = dcrc_pkg::ALL_ONES;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primary_ff <= PRIMARY_RESET;
         master_ff  <= 1'b0;
         enable_ff  <= '0;
         flag_ff    <= '0;
      end else begin
         primary_ff <= primary_in;
         master_ff  <= master_in;
         enable_ff  <= enable_in;
         flag_ff    <= flag_in;
      end
   end

endmodule

FILE: rtl/dma_channel_register_controller.sv
// ============================================================================
// dma_channel_register_controller: DMA register window for seven channels
// Decodes 32-bit register reads and writes, keeps channel and interrupt
// state and issues a transfer descriptor when a write starts a channel.
// ============================================================================
//
//  channel    dir  handshake          payload
//  req_chan   in   valid/ready        command, reg_offset, write_data
//  rsp_chan   out  valid/ready        read_data, irq_level, start_* descriptor
//
//  One item per cycle while results are taken; each item is held in the input
//  register and is decoded and committed as it moves to the result register,
//  which offers its result.
//  Reset (synchronous, active high) empties both registers and restores the
//  register file reset values.
//  A stalled response holds the result; the input register keeps taking an
//  item as long as the pending one can move on.
// ----------------------------------------------------------------------------
module dma_channel_register_controller (
   input  logic        clock,
   input  logic        reset,
   dcrc_req_if.sink    req_chan,
   dcrc_rsp_if.source  rsp_chan
);

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff;
   logic [7:0]  in_off_ff;
   logic [31:0] in_data_ff;

   // result register
   logic                out_valid_ff, out_valid_in;
   logic [31:0]         out_rdata_ff;
   logic                out_irq_ff;
   dcrc_pkg::start_type out_start_ff;

   logic                              fire;
   logic                              accept;
   logic [1:0]                        lane;
   logic [2:0]                        chan;
   logic [1:0]                        regsel;
   dcrc_pkg::access_type              access;
   dcrc_pkg::start_type               start;
   logic [dcrc_pkg::CHANNELS-1:0]     master_en;
   logic                              irq_next;
   logic [31:0]                       chan_rd;
   logic [31:0]                       common_rd;
   logic                              unimpl;
   logic [31:0]                       rdata;

   // item moves from input to result register when the result slot frees up
   assign fire   = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !in_valid_ff || fire;

   assign lane   = in_off_ff[1:0];
   assign regsel = in_off_ff[3:2];
   assign chan   = in_off_ff[6:4];

   always_comb begin
      access.strobe = fire;
      access.write  = (in_cmd_ff == dcrc_pkg::CMD_WRITE);
      access.chan   = chan;
      access.regsel = regsel;
      access.value  = in_data_ff << {lane, 3'b000};
   end

   dcrc_chan_regs u_chan (
      .clock     (clock),
      .reset     (reset),
      .access    (access),
      .master_en (master_en),
      .start     (start),
      .rd_value  (chan_rd)
   );

   dcrc_common_regs u_common (
      .clock     (clock),
      .reset     (reset),
      .access    (access),
      .start     (start),
      .master_en (master_en),
      .irq_next  (irq_next),
      .rd_value  (common_rd)
   );

   // unimplemented: spare channel register, upper common registers,
   // channels beyond the implemented count; reads all ones, unshifted
   always_comb begin
      if (chan == dcrc_pkg::COMMON_CHAN) begin
         unimpl = (regsel != dcrc_pkg::REG_PRIMARY) && (regsel != dcrc_pkg::REG_IRQ);
      end else begin
         unimpl = (chan >= dcrc_pkg::CHAN_LIMIT) || (regsel == dcrc_pkg::REG_UNUSED);
      end
      if (in_cmd_ff == dcrc_pkg::CMD_WRITE) begin
         rdata = '0;
      end else if (unimpl) begin
         rdata = dcrc_pkg::ALL_ONES;
      end else if (chan == dcrc_pkg::COMMON_CHAN) begin
         rdata = common_rd >> {lane, 3'b000};
      end else begin
         rdata = chan_rd >> {lane, 3'b000};
      end
   end

   assign in_valid_in  = accept || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (accept) begin
         in_cmd_ff  <= req_chan.command;
         in_off_ff  <= req_chan.reg_offset;
         in_data_ff <= req_chan.write_data;
      end
      if (fire) begin
         out_rdata_ff <= rdata;
         out_irq_ff   <= irq_next;
         out_start_ff <= start;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.read_data         = out_rdata_ff;
   assign rsp_chan.irq_level         = out_irq_ff;
   assign rsp_chan.start_valid       = out_start_ff.valid;
   assign rsp_chan.start_channel     = out_start_ff.chan;
   assign rsp_chan.start_linked_list = out_start_ff.linked_list;
   assign rsp_chan.start_to_ram      = out_start_ff.to_ram;
   assign rsp_chan.start_decrement   = out_start_ff.decrement;
   assign rsp_chan.start_base        = out_start_ff.base;
   assign rsp_chan.start_words       = out_start_ff.words;
   assign rsp_chan.start_completes   = out_start_ff.completes;

   // a committed item always lands in the result register
   assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("committed item lost");

   // descriptors only come from implemented channels
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_start_ff.valid |-> out_start_ff.chan < dcrc_pkg::CHAN_LIMIT)
      else $error("start from unimplemented channel");

   // only writes start transfers, and writes return zero data
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_start_ff.valid |-> out_rdata_ff == '0)
      else $error("start on a read access");

endmodule

FILE: tb/dma_channel_register_controller_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// dma_channel_register_controller_tb: register window scoreboard bench
// Drives bus reads and writes into the DMA register window, keeps a shadow
// of every channel and interrupt register, predicts read data, interrupt
// level and start descriptors per item, and compares them in order.
// ============================================================================
module dma_channel_register_controller_tb;
   import dcrc_pkg::*;

   // Bus item and the reply it should produce.
   typedef struct packed {
      logic        command;
      logic [7:0]  reg_offset;
      logic [31:0] write_data;
   } bus_access_t;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      start_type   start;
   } bus_reply_t;

   // Sync modes of the channel control field.
   localparam logic [1:0] SYNC_MANUAL  = 2'd0;
   localparam logic [1:0] SYNC_REQUEST = 2'd1;
   localparam logic [1:0] SYNC_LIST    = 2'd2;
   localparam logic [1:0] SYNC_KEEP    = 2'd3;

   // Channel with forced direction/step/sync, and the only channel whose
   // linked-list transfers complete.
   localparam logic [2:0] FIXED_CHAN     = 3'd6;
   localparam logic [2:0] LIST_DONE_CHAN = 3'd2;

   // Enable and trigger: packed control bits and their bus positions.
   localparam int CTRL_ENABLE  = 11;
   localparam int CTRL_TRIGGER = 12;
   localparam int BUS_ENABLE   = 24;
   localparam int BUS_TRIGGER  = 28;

   localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES = 40;    // latency plus a full receiver stall

   logic clock = 1'b0;
   logic reset;

   dcrc_req_if req_bus ();
   dcrc_rsp_if rsp_bus ();

   dma_channel_register_controller dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #2 clock = ~clock;

   // Shadow register file.
   logic [23:0]         shadow_base  [CHANNELS];
   logic [16:0]         shadow_size  [CHANNELS];
   logic [15:0]         shadow_count [CHANNELS];
   logic [14:0]         shadow_ctrl  [CHANNELS];
   logic [CHANNELS-1:0] shadow_master_en;
   logic [31:0]         shadow_primary;
   logic                shadow_irq_master;
   logic [6:0]          shadow_irq_en;
   logic [6:0]          shadow_irq_flag;
   logic [6:0]          shadow_irq_mode;
   logic                shadow_irq_line;

   bus_access_t pending_accesses[$];  // items not yet offered to the block
   bus_reply_t  replies_due[$];       // predicted replies, oldest first

   // Handshake flags, set at the rising edge, used by the falling-edge drivers.
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // Idle shaping; a calm side never waits.
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;
   int   send_gap = 0;
   int   hold_gap = 0;

   int mismatches   = 0;
   int quiet_cycles = 0;

   function automatic logic [7:0] reg_addr(input logic [2:0] ch, input logic [1:0] rsel,
                                           input logic [1:0] lane);
      return {1'b0, ch, rsel, lane};
   endfunction

   // --------------------------------------------------------------------------
   // Predictor: applies one access to the shadow state, returns the reply.
   // --------------------------------------------------------------------------
   task automatic predict_register_access(input bus_access_t acc, output bus_reply_t rep);
      logic [2:0]  ch;
      logic [1:0]  rsel;
      logic [1:0]  lane;
      logic [31:0] val;
      logic [31:0] view;
      logic        hit;
      logic [14:0] c;
      logic [1:0]  sync;
      logic        from_ram;
      logic        done;
      logic [31:0] words;

      ch   = acc.reg_offset[6:4];   // bit 7 does not take part in decode
      rsel = acc.reg_offset[3:2];
      lane = acc.reg_offset[1:0];
      rep  = '0;

      if (acc.command == CMD_READ) begin
         hit  = 1'b0;
         view = '0;
         if (ch != COMMON_CHAN) begin
            if (ch < CHAN_LIMIT && rsel != REG_UNUSED) begin
               hit = 1'b1;
               case (rsel)
                  REG_BASE: view = {8'h00, shadow_base[ch]};
                  // A stored size of 0x10000 shows up in bit 16.
                  REG_SIZE: view = {shadow_count[ch], 16'h0000} | {15'h0000, shadow_size[ch]};
                  default: begin
                     c           = shadow_ctrl[ch];
                     view[0]     = c[0];
                     view[1]     = c[1];
                     view[8]     = c[2];
                     view[10:9]  = c[4:3];
                     view[18:16] = c[7:5];
                     view[22:20] = c[10:8];
                     view[24]    = c[CTRL_ENABLE];
                     view[28]    = c[CTRL_TRIGGER];
                     view[30:29] = c[14:13];
                  end
               endcase
            end
         end else if (rsel == REG_PRIMARY) begin
            hit  = 1'b1;
            view = shadow_primary;
         end else if (rsel == REG_IRQ) begin
            // Mode bits are write-only.
            hit  = 1'b1;
            view = {shadow_irq_line, shadow_irq_flag, shadow_irq_master, shadow_irq_en, 16'h0};
         end
         rep.read_data = hit ? (view >> {lane, 3'b000}) : ALL_ONES;
      end else begin
         val = acc.write_data << {lane, 3'b000};
         if (ch != COMMON_CHAN) begin
            if (ch < CHAN_LIMIT && rsel != REG_UNUSED) begin
               case (rsel)
                  REG_BASE: shadow_base[ch] = val[23:0];
                  REG_SIZE: begin
                     shadow_size[ch]  = (val[15:0] == 16'h0) ? 17'h10000 : {1'b0, val[15:0]};
                     shadow_count[ch] = val[31:16];
                  end
                  default: begin
                     c = '0;
                     if (ch == FIXED_CHAN) begin
                        // decrement, to RAM, manual; only enable, trigger, bit 30 stick
                        c[1]            = 1'b1;
                        c[CTRL_ENABLE]  = val[BUS_ENABLE];
                        c[CTRL_TRIGGER] = val[BUS_TRIGGER];
                        c[14]           = val[30];
                     end else begin
                        c[0]            = val[0];
                        c[1]            = val[1];
                        c[2]            = val[8];
                        c[4:3]          = (val[10:9] == SYNC_KEEP) ? shadow_ctrl[ch][4:3]
                                                                   : val[10:9];
                        c[7:5]          = val[18:16];
                        c[10:8]         = val[22:20];
                        c[CTRL_ENABLE]  = val[BUS_ENABLE];
                        c[CTRL_TRIGGER] = val[BUS_TRIGGER];
                        c[14:13]        = val[30:29];
                     end
                     shadow_ctrl[ch] = c;
                  end
               endcase

               // Any channel write may start the channel.
               c    = shadow_ctrl[ch];
               sync = c[4:3];
               if (shadow_master_en[ch] && c[CTRL_ENABLE] &&
                   (sync != SYNC_MANUAL || c[CTRL_TRIGGER])) begin
                  from_ram = c[0];
                  if (sync == SYNC_LIST) begin
                     words = '0;
                     done  = from_ram && ch == LIST_DONE_CHAN;
                  end else begin
                     words = (sync == SYNC_MANUAL) ? 32'(shadow_size[ch])
                                                   : 32'(shadow_count[ch]) * 32'(shadow_size[ch]);
                     done  = !from_ram || ch == 3'd0 || ch == 3'd2 || ch == 3'd4;
                  end
                  if (done)
                     shadow_irq_flag[ch] = shadow_irq_flag[ch] | shadow_irq_en[ch];
                  shadow_irq_line = shadow_irq_master && |(shadow_irq_flag & shadow_irq_en);
                  shadow_ctrl[ch][CTRL_ENABLE]  = 1'b0;
                  shadow_ctrl[ch][CTRL_TRIGGER] = 1'b0;

                  rep.start.valid       = 1'b1;
                  rep.start.chan        = ch;
                  rep.start.linked_list = (sync == SYNC_LIST);
                  rep.start.to_ram      = !from_ram;
                  rep.start.decrement   = c[1];
                  rep.start.base        = shadow_base[ch];
                  rep.start.words       = words;
                  rep.start.completes   = done;
               end
            end
         end else if (rsel == REG_PRIMARY) begin
            shadow_primary = val;
            for (int i = 0; i < CHANNELS; i++)
               shadow_master_en[i] = val[3 + 4 * i];
         end else if (rsel == REG_IRQ) begin
            shadow_irq_master = val[23];
            shadow_irq_flag   = shadow_irq_flag & ~val[30:24];  // write one to clear
            shadow_irq_en     = val[22:16];
            shadow_irq_mode   = val[6:0];
            shadow_irq_line   = shadow_irq_master && |(shadow_irq_flag & shadow_irq_en);
         end
      end
      rep.irq_level = shadow_irq_line;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic queue_access(input logic cmd, input logic [7:0] off, input logic [31:0] data);
      bus_access_t acc;
      acc.command    = cmd;
      acc.reg_offset = off;
      acc.write_data = data;
      pending_accesses.push_back(acc);
   endtask

   // Random traffic: mostly complete channel setups so starts actually fire,
   // plus interrupt and enable traffic, readbacks and raw noise.
   task automatic queue_random_traffic(input int count);
      int          made;
      int          pick;
      logic [2:0]  ch;
      logic [31:0] d;
      made = 0;
      while (made < count) begin
         pick = $urandom_range(0, 99);
         ch   = 3'($urandom_range(0, CHANNELS - 1));
         if (pick < 30) begin
            queue_access(CMD_WRITE, reg_addr(ch, REG_BASE, 2'd0), $urandom);
            d = $urandom;
            if (d[2:0] == 3'd0)
               d[15:0] = 16'h0000;       // size zero means 0x10000
            queue_access(CMD_WRITE, reg_addr(ch, REG_SIZE, 2'd0), d);
            d = $urandom;
            d[BUS_ENABLE] = 1'b1;
            queue_access(CMD_WRITE, reg_addr(ch, REG_CTRL, 2'd0), d);
            made += 3;
            if ($urandom_range(0, 1) == 0) begin
               queue_access(CMD_READ, reg_addr(ch, 2'($urandom_range(0, 2)), 2'($urandom)),
                            $urandom);
               made++;
            end
         end else if (pick < 45) begin
            queue_access(CMD_READ, {1'($urandom), 3'($urandom), 2'($urandom), 2'($urandom)},
                         $urandom);
            made++;
         end else if (pick < 55) begin
            d = $urandom;
            if ($urandom_range(0, 3) != 0)
               d[23] = 1'b1;             // keep the master on most of the time
            queue_access(CMD_WRITE, reg_addr(COMMON_CHAN, REG_IRQ, 2'd0), d);
            made++;
         end else if (pick < 65) begin
            d = $urandom;
            if ($urandom_range(0, 3) != 0)
               d = d | 32'h0888_8888;    // all channel master enables
            queue_access(CMD_WRITE, reg_addr(COMMON_CHAN, REG_PRIMARY, 2'd0), d);
            made++;
         end else begin
            queue_access(1'($urandom), 8'($urandom), $urandom);
            made++;
         end
      end
   endtask

   // Sender stays quiet until every predicted reply has been seen.
   task automatic wait_until_drained();
      while (pending_accesses.size() != 0 || req_bus.valid || replies_due.size() != 0)
         @(negedge clock);
   endtask

   // --------------------------------------------------------------------------
   // Request driver: falling edge, one item at a time, random gap before each.
   // --------------------------------------------------------------------------
   always @(negedge clock) begin : drive_requests
      bus_access_t nxt;
      if (!reset) begin
         if (!req_bus.valid || req_taken) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_accesses.size() != 0) begin
               nxt = pending_accesses.pop_front();
               req_bus.command    <= nxt.command;
               req_bus.reg_offset <= nxt.reg_offset;
               req_bus.write_data <= nxt.write_data;
               req_bus.valid      <= 1'b1;
               send_gap = req_calm ? 0 : $urandom_range(0, 16);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Reply side: after each reply, stall ready for a random count.
   always @(negedge clock) begin : drive_ready
      if (!reset) begin
         if (rsp_taken)
            hold_gap = rsp_calm ? 0 : $urandom_range(0, 16);
         if (hold_gap > 0) begin
            hold_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: rising edge. Check replies, predict accepted items, watchdog.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : watch_channels
      bus_reply_t  want;
      bus_access_t took;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_taken = 1'b1;
            if (replies_due.size() == 0) begin
               $error("reply with no access outstanding");
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               check_field("read_data", want.read_data, rsp_bus.read_data);
               check_field("irq_level", 32'(want.irq_level), 32'(rsp_bus.irq_level));
               check_field("start_valid", 32'(want.start.valid), 32'(rsp_bus.start_valid));
               check_field("start_channel", 32'(want.start.chan), 32'(rsp_bus.start_channel));
               check_field("start_linked_list", 32'(want.start.linked_list),
                           32'(rsp_bus.start_linked_list));
               check_field("start_to_ram", 32'(want.start.to_ram), 32'(rsp_bus.start_to_ram));
               check_field("start_decrement", 32'(want.start.decrement),
                           32'(rsp_bus.start_decrement));
               check_field("start_base", 32'(want.start.base), 32'(rsp_bus.start_base));
               check_field("start_words", want.start.words, rsp_bus.start_words);
               check_field("start_completes", 32'(want.start.completes),
                           32'(rsp_bus.start_completes));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            req_taken       = 1'b1;
            took.command    = req_bus.command;
            took.reg_offset = req_bus.reg_offset;
            took.write_data = req_bus.write_data;
            predict_register_access(took, want);
            replies_due.push_back(want);
         end
         if (req_taken || rsp_taken)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus and end of run.
   // --------------------------------------------------------------------------
   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_WRITE;
      req_bus.reg_offset = '0;
      req_bus.write_data = '0;
      rsp_bus.ready      = 1'b0;

      for (int i = 0; i < CHANNELS; i++) begin
         shadow_base[i]  = '0;
         shadow_size[i]  = '0;
         shadow_count[i] = '0;
         shadow_ctrl[i]  = '0;
      end
      shadow_master_en  = '0;
      shadow_primary    = 32'h0765_4321;
      shadow_irq_master = 1'b0;
      shadow_irq_en     = '0;
      shadow_irq_flag   = '0;
      shadow_irq_mode   = '0;
      shadow_irq_line   = 1'b0;

      // Directed pass.
      queue_access(CMD_READ,  reg_addr(COMMON_CHAN, REG_PRIMARY, 2'd0), '0); // reset value
      queue_access(CMD_READ,  reg_addr(COMMON_CHAN, REG_PRIMARY, 2'd3), '0); // top byte lane
      queue_access(CMD_READ,  reg_addr(COMMON_CHAN, REG_IRQ, 2'd0), '0);
      queue_access(CMD_READ,  reg_addr(3'd0, REG_UNUSED, 2'd0), '0);          // all ones
      queue_access(CMD_READ,  reg_addr(COMMON_CHAN, 2'd2, 2'd3), '0);         // unshifted ones
      queue_access(CMD_WRITE, reg_addr(COMMON_CHAN, REG_PRIMARY, 2'd0), 32'h0888_8888);
      queue_access(CMD_WRITE, reg_addr(COMMON_CHAN, REG_IRQ, 2'd0), 32'h00FF_007F);
      queue_access(CMD_WRITE, reg_addr(3'd0, REG_BASE, 2'd0), ALL_ONES);      // base max
      queue_access(CMD_WRITE, reg_addr(3'd0, REG_SIZE, 2'd0), 32'hFFFF_0000); // size 0, max count
      queue_access(CMD_READ,  reg_addr(3'd0, REG_SIZE, 2'd0), '0);
      // ch0 request sync from RAM: largest word count, completes
      queue_access(CMD_WRITE, reg_addr(3'd0, REG_CTRL, 2'd0), 32'h0100_0201);
      // ch2 linked list from RAM: the one list case that completes
      queue_access(CMD_WRITE, reg_addr(3'd2, REG_CTRL, 2'd0), 32'h0100_0401);
      queue_access(CMD_READ,  reg_addr(COMMON_CHAN, REG_IRQ, 2'd0), '0);      // line high
      // channel six forced fields
      queue_access(CMD_WRITE, reg_addr(FIXED_CHAN, REG_CTRL, 2'd0), ALL_ONES);
      queue_access(CMD_READ,  reg_addr(FIXED_CHAN, REG_CTRL, 2'd0), '0);
      // sync three keeps the old sync mode
      queue_access(CMD_WRITE, reg_addr(3'd1, REG_CTRL, 2'd0), 32'h0000_0200);
      queue_access(CMD_WRITE, reg_addr(3'd1, REG_CTRL, 2'd0), 32'h0000_0600);
      queue_access(CMD_READ,  reg_addr(3'd1, REG_CTRL, 2'd0), '0);
      // ch3 manual block from RAM: starts but does not complete
      queue_access(CMD_WRITE, reg_addr(3'd3, REG_CTRL, 2'd0), 32'h1100_0001);
      queue_access(CMD_WRITE, reg_addr(COMMON_CHAN, REG_IRQ, 2'd0), 32'h7FFF_0000); // clear flags
      queue_access(CMD_WRITE, reg_addr(3'd4, REG_BASE, 2'd1), 32'h0012_3456);   // lane shift
      queue_access(CMD_READ,  reg_addr(3'd4, REG_BASE, 2'd2), '0);
      queue_access(CMD_WRITE, {1'b1, 3'd5, REG_SIZE, 2'd0}, '0);                // bit 7 ignored
      queue_access(CMD_WRITE, reg_addr(3'd3, REG_UNUSED, 2'd0), ALL_ONES);      // ignored
      queue_access(CMD_WRITE, reg_addr(COMMON_CHAN, REG_PRIMARY, 2'd0), '0);

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Random phases; between phases the sender waits for every reply.
      for (int phase = 0; phase < 4; phase++) begin
         wait_until_drained();
         @(posedge clock);
         req_calm = (phase == 1 || phase == 2);
         rsp_calm = (phase == 1 || phase == 3);
         queue_random_traffic(100);
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
